FILE: rtl/kphl_pkg.sv
// Package: shared types and constants for the keyword perfect-hash lookup unit.
`timescale 1ns / 1ps
package kphl_pkg;

    // Table geometry; bucket and slot select take the low hash bits
    localparam int BUCKETS     = 128;
    localparam int SLOTS       = 256;
    localparam int MAX_KEY_LEN = 16;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
    localparam logic [63:0] FMIX_C1   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2   = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned FMIX_SHIFT = 33;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_SEED  = 2'd1;
    localparam logic [1:0] KIND_ENTRY = 2'd2;
    localparam logic [1:0] KIND_KEY   = 2'd3;

    // Multiplier operand select
    typedef enum logic [1:0] {
        t_MSEL_FNV = 2'd0,
        t_MSEL_C1  = 2'd1,
        t_MSEL_C2  = 2'd2
    } t_msel;

    // Commands from controller to datapath
    typedef struct packed {
        logic  load_item;    // capture the input item
        logic  fnv_xor;      // acc = hash ^ byte, buffer the byte
        logic  mul_start;    // start a 64x64 multiply on acc
        t_msel mul_sel;
        logic  mix_shift;    // acc ^= acc >> 33
        logic  acc_from_hash;
        logic  hash_from_acc;
        logic  save_h;       // keep finalized hash, read seed
        logic  acc_from_hseed;
        logic  save_slot;    // latch slot, read entry
        logic  cmp_clear;
        logic  cmp_step;     // compare one key byte
        logic  emit;
        logic  clear_lex;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic mul_done;
        logic is_query;
        logic is_last;
        logic cmp_done;
    } t_sts;

endpackage

FILE: rtl/kphl_ctrl.sv
// Controller: sequences hashing, finalization, probing and key compare.
`timescale 1ns / 1ps
module kphl_ctrl
    import kphl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output logic o_busy,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_FNV_MUL, S_FNV_WAIT, S_F1_LOAD, S_F1_SH0, S_F1_M1,
        S_F1_W1, S_F1_SH1, S_F1_M2, S_F1_W2, S_F1_SH2, S_SEED, S_F2_LOAD,
        S_F2_SH0, S_F2_M1, S_F2_W1, S_F2_SH1, S_F2_M2, S_F2_W2, S_F2_SH2,
        S_SLOT, S_ENTRY, S_CMP, S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_cmd   c;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        c = '0;
        c.mul_sel = t_MSEL_FNV;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    c.load_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_query) begin
                    c.fnv_xor = 1'b1;
                    n_state = S_FNV_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FNV_MUL: begin
                c.mul_start = 1'b1;
                c.mul_sel = t_MSEL_FNV;
                n_state = S_FNV_WAIT;
            end
            S_FNV_WAIT: begin
                if (i_sts.mul_done) begin
                    c.hash_from_acc = 1'b1;
                    n_state = i_sts.is_last ? S_F1_LOAD : S_IDLE;
                end
            end
            S_F1_LOAD: begin c.acc_from_hash = 1'b1; n_state = S_F1_SH0; end
            S_F1_SH0:  begin c.mix_shift = 1'b1; n_state = S_F1_M1; end
            S_F1_M1: begin
                c.mul_start = 1'b1; c.mul_sel = t_MSEL_C1; n_state = S_F1_W1;
            end
            S_F1_W1:  begin if (i_sts.mul_done) n_state = S_F1_SH1; end
            S_F1_SH1: begin c.mix_shift = 1'b1; n_state = S_F1_M2; end
            S_F1_M2: begin
                c.mul_start = 1'b1; c.mul_sel = t_MSEL_C2; n_state = S_F1_W2;
            end
            S_F1_W2:  begin if (i_sts.mul_done) n_state = S_F1_SH2; end
            S_F1_SH2: begin c.mix_shift = 1'b1; n_state = S_SEED; end
            S_SEED:   begin c.save_h = 1'b1; n_state = S_F2_LOAD; end
            S_F2_LOAD: begin c.acc_from_hseed = 1'b1; n_state = S_F2_SH0; end
            S_F2_SH0: begin c.mix_shift = 1'b1; n_state = S_F2_M1; end
            S_F2_M1: begin
                c.mul_start = 1'b1; c.mul_sel = t_MSEL_C1; n_state = S_F2_W1;
            end
            S_F2_W1:  begin if (i_sts.mul_done) n_state = S_F2_SH1; end
            S_F2_SH1: begin c.mix_shift = 1'b1; n_state = S_F2_M2; end
            S_F2_M2: begin
                c.mul_start = 1'b1; c.mul_sel = t_MSEL_C2; n_state = S_F2_W2;
            end
            S_F2_W2:  begin if (i_sts.mul_done) n_state = S_F2_SH2; end
            S_F2_SH2: begin c.mix_shift = 1'b1; n_state = S_SLOT; end
            S_SLOT:   begin c.save_slot = 1'b1; n_state = S_ENTRY; end
            S_ENTRY:  begin c.cmp_clear = 1'b1; n_state = S_CMP; end
            S_CMP: begin
                if (i_sts.cmp_done) n_state = S_EMIT;
                else c.cmp_step = 1'b1;
            end
            S_EMIT: begin
                c.emit = 1'b1;
                c.clear_lex = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = c;

endmodule

FILE: rtl/kphl_mul64.sv
// Multi-cycle 64x64 low-half multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module kphl_mul64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);

    logic [1:0]  r_step;
    logic        r_run;
    logic [63:0] r_a, r_b, r_acc;
    logic [31:0] w_x, w_y;
    logic [63:0] w_pp, r_pp;
    logic [1:0]  r_pstep;
    logic        r_pv;

    // Pick partial product operands: lo*lo, lo*hi, hi*lo
    always_comb begin
        case (r_step)
            2'd0:    begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            2'd1:    begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            default: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
        endcase
    end
    assign w_pp = {32'd0, w_x} * {32'd0, w_y};

    // Issue one partial product per cycle, register, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_step <= 2'd0; r_pv <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_pv   <= r_run;
            if (i_start) begin
                r_run <= 1'b1; r_step <= 2'd0;
            end else if (r_run) begin
                if (r_step == 2'd2) r_run <= 1'b0;
                r_step <= r_step + 2'd1;
            end
            if (r_pv && r_pstep == 2'd2) o_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a; r_b <= i_b;
        end
        r_pp <= w_pp;
        r_pstep <= r_step;
        if (r_pv) begin
            if (r_pstep == 2'd0) r_acc <= r_pp;
            else r_acc <= r_acc + {r_pp[31:0], 32'd0};
        end
    end

    assign o_p = r_acc;

endmodule

FILE: rtl/kphl_dp.sv
// Datapath: hash registers, multiplier, tables, key store and compare.
`timescale 1ns / 1ps
module kphl_dp
    import kphl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic [7:0] i_target_index,
    input  logic [3:0] i_byte_position,
    input  logic [4:0] i_key_length,
    input  logic [7:0] i_token_code,
    input  logic       i_entry_valid,
    input  logic [7:0] i_ident_code,
    output logic       o_result_valid,
    output logic [7:0] o_result_code,
    output logic       o_matched,
    output logic [7:0] o_probed_slot
);

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int LW  = $clog2(MAX_KEY_LEN + 1);
    localparam int KSD = SLOTS * MAX_KEY_LEN;
    localparam int KAW = SW + KW;

    // Captured item
    logic [1:0] r_kind;
    logic [7:0] r_data, r_tgt, r_code;
    logic [3:0] r_pos;
    logic [4:0] r_klen;
    logic       r_last, r_valid;

    logic [63:0] r_hash, r_acc, r_h;
    logic [LW-1:0] r_len;
    logic          r_too_long;
    logic [7:0]    r_lex [MAX_KEY_LEN];

    logic [7:0] r_seeds [BUCKETS];
    logic [BUCKETS-1:0] r_seed_v;
    logic [7:0] r_seed;
    logic [SLOTS-1:0] r_evalid;
    logic [12:0] r_entry [SLOTS];   // {length, code}
    logic [7:0]  r_key [KSD];
    logic [SW-1:0] r_slot;
    logic          r_e_valid;
    logic [4:0]    r_e_len;
    logic [7:0]    r_e_code;
    logic [KW:0]   r_ci;       // compare index, one extra bit
    logic [LW:0]   r_rd_i;
    logic [7:0]    r_kq;
    logic          r_kq_v;
    logic          r_hit;
    logic          r_done;
    logic          r_wr_pend;

    logic [63:0] w_mb, w_mp;
    logic        w_mdone;

    always_comb begin
        case (i_cmd.mul_sel)
            t_MSEL_C1: w_mb = FMIX_C1;
            t_MSEL_C2: w_mb = FMIX_C2;
            default:   w_mb = FNV_PRIME;
        endcase
    end

    kphl_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (r_acc),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    logic w_tgt_slot_ok, w_tgt_bkt_ok, w_pos_ok;
    assign w_tgt_bkt_ok  = ({24'd0, r_tgt} < 32'(BUCKETS));
    assign w_tgt_slot_ok = ({24'd0, r_tgt} < 32'(SLOTS));
    assign w_pos_ok      = ({28'd0, r_pos} < 32'(MAX_KEY_LEN));

    // Capture item, hash and lexeme state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind <= i_kind; r_data <= i_data_byte; r_last <= i_last;
            r_tgt <= i_target_index; r_pos <= i_byte_position;
            r_klen <= i_key_length; r_code <= i_token_code; r_valid <= i_entry_valid;
        end
        if (i_cmd.fnv_xor) begin
            r_acc <= r_hash ^ {56'd0, r_data};
            if (!r_too_long && r_len < LW'(MAX_KEY_LEN)) r_lex[r_len[KW-1:0]] <= r_data;
        end else if (i_cmd.acc_from_hash) begin
            r_acc <= r_hash;
        end else if (i_cmd.acc_from_hseed) begin
            r_acc <= r_h ^ {56'd0, r_seed};
        end else if (i_cmd.mix_shift) begin
            r_acc <= r_acc ^ (r_acc >> FMIX_SHIFT);
        end else if (w_mdone) begin
            r_acc <= w_mp;
        end
        if (i_cmd.save_h) r_h <= r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS; r_len <= '0; r_too_long <= 1'b0;
        end else begin
            if (i_cmd.fnv_xor && !r_too_long) begin
                if (r_len < LW'(MAX_KEY_LEN)) r_len <= r_len + 1'b1;
                else r_too_long <= 1'b1;
            end
            if (i_cmd.hash_from_acc) r_hash <= w_mp;
            if (i_cmd.clear_lex) begin
                r_hash <= FNV_BASIS; r_len <= '0; r_too_long <= 1'b0;
            end
        end
    end

    // Write pending for one cycle after capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wr_pend <= 1'b0;
        else r_wr_pend <= i_cmd.load_item;
    end

    // Seed valid bits: a bucket never written reads as a zero seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_v <= '0;
        end else if (r_wr_pend && r_kind == KIND_SEED && w_tgt_bkt_ok) begin
            r_seed_v[r_tgt[BW-1:0]] <= 1'b1;
        end
    end

    // Seed memory
    always_ff @(posedge i_clk) begin
        if (r_wr_pend && r_kind == KIND_SEED && w_tgt_bkt_ok)
            r_seeds[r_tgt[BW-1:0]] <= r_data;
    end

    // Entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evalid <= '0;
        end else if (r_wr_pend && r_kind == KIND_ENTRY && w_tgt_slot_ok) begin
            r_evalid[r_tgt[SW-1:0]] <= r_valid;
        end
    end

    // Entry and key memories
    always_ff @(posedge i_clk) begin
        if (r_wr_pend && r_kind == KIND_ENTRY && w_tgt_slot_ok)
            r_entry[r_tgt[SW-1:0]] <= {r_klen, r_code};
        if (i_cmd.save_slot) begin
            r_e_len  <= r_entry[r_acc[SW-1:0]][12:8];
            r_e_code <= r_entry[r_acc[SW-1:0]][7:0];
            r_e_valid <= r_evalid[r_acc[SW-1:0]];
            r_slot <= r_acc[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_pend && r_kind == KIND_KEY && w_tgt_slot_ok && w_pos_ok)
            r_key[{r_tgt[SW-1:0], r_pos[KW-1:0]}] <= r_data;
        r_kq <= r_key[KAW'({r_slot, r_ci[KW-1:0]})];
    end

    // Seed read at bucket select
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_h)
            r_seed <= r_seed_v[r_acc[BW-1:0]] ? r_seeds[r_acc[BW-1:0]] : 8'd0;
    end

    // Byte compare: one key byte per cycle, key read data registered
    logic w_len_eq;
    assign w_len_eq = ({{(8-LW){1'b0}}, r_len} == {3'd0, r_e_len}) &&
                      !r_too_long && r_e_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= '0; r_kq_v <= 1'b0; r_hit <= 1'b0; r_done <= 1'b0;
            r_rd_i <= '0;
        end else if (i_cmd.cmp_clear) begin
            r_ci <= '0; r_kq_v <= 1'b0; r_hit <= w_len_eq; r_rd_i <= '0;
            r_done <= !w_len_eq || (r_len == '0);
        end else if (i_cmd.cmp_step) begin
            r_kq_v <= 1'b1;
            if ((r_ci < r_len) && !r_done) r_ci <= r_ci + 1'b1;
            if (r_kq_v) begin
                if (r_kq != r_lex[r_rd_i[KW-1:0]]) r_hit <= 1'b0;
                r_rd_i <= r_rd_i + 1'b1;
                if ((r_rd_i + 1'b1) == {1'b0, r_len}) r_done <= 1'b1;
            end
        end
    end

    assign o_sts.mul_done = w_mdone;
    assign o_sts.is_query = (r_kind == KIND_QUERY);
    assign o_sts.is_last  = r_last;
    assign o_sts.cmp_done = r_done;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_result_code <= r_hit ? r_e_code : i_ident_code;
            o_matched     <= r_hit;
            o_probed_slot <= 8'(r_slot);
        end
    end

endmodule

FILE: rtl/keyword_perfect_hash_lookup_unit.sv
// Top level: keyword perfect-hash lookup unit.
`timescale 1ns / 1ps
// Lexeme bytes, seed/entry/key writes arrive as items on start while busy
// is low. A write item holds busy only through its decode state. A non-final
// query byte holds busy through decode and the 64-bit FNV multiply, done as
// three 32x32 partial products. A final byte adds two Murmur finalizer passes
// (four more multiplies), the seed and slot reads and a key compare of one
// byte per cycle, which is skipped when the probed slot's length differs.
// The result appears for one cycle on o_result_valid, in the first cycle with
// busy low; the receiver cannot stall, so it must take it then. No clearing
// pass follows reset.
module keyword_perfect_hash_lookup_unit
    import kphl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic [7:0] i_target_index,
    input  logic [3:0] i_byte_position,
    input  logic [4:0] i_key_length,
    input  logic [7:0] i_token_code,
    input  logic       i_entry_valid,
    output logic       o_result_valid,
    output logic [7:0] o_result_code,
    output logic       o_matched,
    output logic [7:0] o_probed_slot
);

    logic [7:0] r_ident_code;
    t_cmd w_cmd;
    t_sts w_sts;

    // Hold identifier code register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident_code <= 8'd0;
        end else if (i_cfg_we) begin
            r_ident_code <= i_cfg_wdata;
        end
    end

    kphl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    kphl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (i_kind),
        .i_data_byte     (i_data_byte),
        .i_last          (i_last),
        .i_target_index  (i_target_index),
        .i_byte_position (i_byte_position),
        .i_key_length    (i_key_length),
        .i_token_code    (i_token_code),
        .i_entry_valid   (i_entry_valid),
        .i_ident_code    (r_ident_code),
        .o_result_valid  (o_result_valid),
        .o_result_code   (o_result_code),
        .o_matched       (o_matched),
        .o_probed_slot   (o_probed_slot)
    );

endmodule

FILE: tb/tb_keyword_perfect_hash_lookup_unit.sv
// Testbench for the keyword perfect-hash lookup unit: scoreboard plus driver tasks.
`timescale 1ns / 1ps
module tb_keyword_perfect_hash_lookup_unit;
    import kphl_pkg::*;

    localparam int N_BUCKETS  = 128;
    localparam int N_SLOTS    = 256;
    localparam int KEY_MAX    = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYC  = 100;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [7:0] target;
        logic [3:0] pos;
        logic [4:0] klen;
        logic [7:0] code;
        logic       valid;
    } lex_item_t;

    typedef struct {
        logic [7:0] code;
        logic       matched;
        logic [7:0] slot;
    } lookup_t;

    // Predicts lookups from the transfers seen and checks each result against them.
    class keyword_scoreboard;
        logic [7:0]  ident_code;
        logic [63:0] run_hash;
        logic [7:0]  lex_buf[KEY_MAX];
        int          lex_len;
        bit          too_long;
        logic [7:0]  seeds[N_BUCKETS];
        bit          ent_valid[N_SLOTS];
        logic [4:0]  ent_len[N_SLOTS];
        logic [7:0]  ent_code[N_SLOTS];
        logic [7:0]  keys[N_SLOTS][KEY_MAX];
        bit          key_set[N_SLOTS][KEY_MAX];
        lookup_t     lookups[$];
        int          fails;

        function new();
            ident_code = 8'd0;
            run_hash   = FNV_BASIS;
            lex_len    = 0;
            too_long   = 0;
            fails      = 0;
            for (int i = 0; i < N_BUCKETS; i++) seeds[i] = 8'd0;
            for (int i = 0; i < N_SLOTS; i++) begin
                ent_valid[i] = 0;
                ent_len[i]   = 5'd0;
                ent_code[i]  = 8'd0;
                for (int j = 0; j < KEY_MAX; j++) begin
                    keys[i][j]    = 8'd0;
                    key_set[i][j] = 0;
                end
            end
        endfunction

        function logic [63:0] fmix(logic [63:0] v);
            v = v ^ (v >> FMIX_SHIFT);
            v = v * FMIX_C1;
            v = v ^ (v >> FMIX_SHIFT);
            v = v * FMIX_C2;
            v = v ^ (v >> FMIX_SHIFT);
            return v;
        endfunction

        // Slot that a finished FNV hash lands on with the current seeds.
        function logic [7:0] slot_of_hash(logic [63:0] fnv);
            logic [63:0] h;
            logic [63:0] s;
            h = fmix(fnv);
            s = fmix(h ^ {56'd0, seeds[h[6:0]]});
            return s[7:0];
        endfunction

        function logic [7:0] slot_of_lexeme(logic [7:0] lex[$]);
            logic [63:0] h;
            h = FNV_BASIS;
            foreach (lex[i]) h = (h ^ {56'd0, lex[i]}) * FNV_PRIME;
            return slot_of_hash(h);
        endfunction

        function bit keys_ready(logic [7:0] slot, int len);
            for (int i = 0; i < len; i++)
                if (!key_set[slot][i]) return 0;
            return 1;
        endfunction

        function void note_item(lex_item_t it);
            lookup_t     r;
            logic [7:0]  slot;
            bit          hit;
            case (it.kind)
                KIND_SEED: begin
                    if (it.target < N_BUCKETS) seeds[it.target] = it.data;
                end
                KIND_ENTRY: begin
                    ent_valid[it.target] = it.valid;
                    ent_len[it.target]   = it.klen;
                    ent_code[it.target]  = it.code;
                end
                KIND_KEY: begin
                    keys[it.target][it.pos]    = it.data;
                    key_set[it.target][it.pos] = 1;
                end
                default: begin
                    run_hash = (run_hash ^ {56'd0, it.data}) * FNV_PRIME;
                    if (!too_long) begin
                        if (lex_len < KEY_MAX) begin
                            lex_buf[lex_len] = it.data;
                            lex_len++;
                        end else begin
                            too_long = 1;
                        end
                    end
                    if (it.last) begin
                        slot = slot_of_hash(run_hash);
                        hit  = !too_long && ent_valid[slot] && (ent_len[slot] == lex_len);
                        if (hit)
                            for (int i = 0; i < lex_len; i++)
                                if (keys[slot][i] != lex_buf[i]) hit = 0;
                        r.code    = hit ? ent_code[slot] : ident_code;
                        r.matched = hit;
                        r.slot    = slot;
                        lookups.push_back(r);
                        run_hash = FNV_BASIS;
                        lex_len  = 0;
                        too_long = 0;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [7:0] code, logic matched, logic [7:0] slot);
            lookup_t e;
            if (lookups.size() == 0) begin
                $error("unexpected result: code %0d matched %0d slot %0d", code, matched, slot);
                fails++;
                return;
            end
            e = lookups.pop_front();
            if (code !== e.code) begin
                $error("result_code: expected %0d, actual %0d", e.code, code);
                fails++;
            end
            if (matched !== e.matched) begin
                $error("matched: expected %0d, actual %0d", e.matched, matched);
                fails++;
            end
            if (slot !== e.slot) begin
                $error("probed_slot: expected %0d, actual %0d", e.slot, slot);
                fails++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic [1:0] i_kind;
    logic [7:0] i_data_byte;
    logic       i_last;
    logic [7:0] i_target_index;
    logic [3:0] i_byte_position;
    logic [4:0] i_key_length;
    logic [7:0] i_token_code;
    logic       i_entry_valid;
    logic       o_result_valid;
    logic [7:0] o_result_code;
    logic       o_matched;
    logic [7:0] o_probed_slot;

    keyword_scoreboard sb;
    int  transfers;
    int  idle_cycles;
    int  items_sent;
    int  last_transfers;
    bit  no_gaps;

    keyword_perfect_hash_lookup_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .i_target_index (i_target_index),
        .i_byte_position(i_byte_position),
        .i_key_length   (i_key_length),
        .i_token_code   (i_token_code),
        .i_entry_valid  (i_entry_valid),
        .o_result_valid (o_result_valid),
        .o_result_code  (o_result_code),
        .o_matched      (o_matched),
        .o_probed_slot  (o_probed_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Check every result in the cycle it is shown.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            sb.check_result(o_result_code, o_matched, o_probed_slot);
            transfers++;
        end
    end

    // Abort when nothing moves for too long.
    always @(posedge i_clk) begin
        if (transfers != last_transfers) begin
            last_transfers = transfers;
            idle_cycles    = 0;
        end else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Present one item and hold it until the block takes it.
    task automatic send(lex_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // A valid entry may only point at key bytes that exist.
        if (it.kind == KIND_ENTRY && it.valid && it.klen >= 1 && it.klen <= KEY_MAX
                && !sb.keys_ready(it.target, it.klen))
            it.valid = 1'b0;
        i_kind          <= it.kind;
        i_data_byte     <= it.data;
        i_last          <= it.last;
        i_target_index  <= it.target;
        i_byte_position <= it.pos;
        i_key_length    <= it.klen;
        i_token_code    <= it.code;
        i_entry_valid   <= it.valid;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        transfers++;
        items_sent++;
    endtask

    function automatic lex_item_t rand_item();
        lex_item_t it;
        it.kind   = 2'($urandom_range(0, 3));
        it.data   = 8'($urandom_range(0, 255));
        it.last   = ($urandom_range(0, 3) == 0);
        it.target = 8'($urandom_range(0, 255));
        it.pos    = 4'($urandom_range(0, 15));
        it.klen   = 5'($urandom_range(0, 31));
        it.code   = 8'($urandom_range(0, 255));
        it.valid  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_write(logic [1:0] kind, logic [7:0] target, logic [7:0] data,
                              logic [3:0] pos, logic [4:0] klen, logic [7:0] code,
                              logic valid);
        lex_item_t it;
        it = rand_item();
        it.kind = kind; it.target = target; it.data = data; it.pos = pos;
        it.klen = klen; it.code = code; it.valid = valid;
        send(it);
    endtask

    task automatic send_lexeme(logic [7:0] lex[$]);
        lex_item_t it;
        foreach (lex[i]) begin
            it = rand_item();
            it.kind = KIND_QUERY;
            it.data = lex[i];
            it.last = (i == lex.size() - 1);
            send(it);
        end
    endtask

    // Store a keyword in the slot it hashes to, optionally disturb what is stored, then look the keyword up.
    task automatic keyword_roundtrip(logic [7:0] lex[$], int twist);
        logic [7:0] slot;
        logic [7:0] probe[$];
        int         klen;
        slot = sb.slot_of_lexeme(lex);
        klen = lex.size();
        for (int i = 0; i < klen && i < KEY_MAX; i++)
            send_write(KIND_KEY, slot, lex[i], 4'(i), 0, 0, 0);
        if (twist == 3 && klen < KEY_MAX) begin
            for (int i = klen; i < KEY_MAX; i++)
                send_write(KIND_KEY, slot, 8'($urandom_range(0, 255)), 4'(i), 0, 0, 0);
            klen = KEY_MAX;
        end
        send_write(KIND_ENTRY, slot, 0, 0, 5'(klen > KEY_MAX ? KEY_MAX : klen),
                   8'($urandom_range(0, 255)), 1);
        probe = lex;
        // Corrupt one stored byte so the compare fails late.
        if (twist == 1)
            send_write(KIND_KEY, slot, ~lex[lex.size() - 1], 4'(lex.size() - 1), 0, 0, 0);
        // A seed change can move the lexeme to another slot.
        if (twist == 2)
            send_write(KIND_SEED, 8'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                       0, 0, 0, 0);
        send_lexeme(probe);
    endtask

    function automatic void rand_lexeme(ref logic [7:0] lex[$], input int len);
        lex.delete();
        for (int i = 0; i < len; i++) lex.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_ident(logic [7:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.ident_code = v;
    endtask

    task automatic directed();
        logic [7:0] lex[$];
        lex = '{8'h00};
        send_lexeme(lex);
        lex = '{8'hff};
        send_lexeme(lex);
        send_write(KIND_SEED, 127, 8'hff, 0, 0, 0, 0);
        send_write(KIND_SEED, 128, 8'h5a, 0, 0, 0, 0);
        send_write(KIND_SEED, 255, 8'ha5, 0, 0, 0, 0);
        send_write(KIND_ENTRY, 0, 0, 0, 5'd31, 8'hff, 1);
        send_write(KIND_KEY, 255, 8'hff, 4'hf, 0, 0, 0);
        rand_lexeme(lex, KEY_MAX);
        keyword_roundtrip(lex, 0);
        // Same keyword followed by one more byte: too long, never a match.
        lex.push_back(8'h41);
        send_lexeme(lex);
        // Stored length above the lexeme length.
        lex = '{8'h69, 8'h66};
        keyword_roundtrip(lex, 3);
    endtask

    task automatic random_phase(int count);
        logic [7:0] lex[$];
        lex_item_t  it;
        int         sel;
        int         stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                rand_lexeme(lex, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16)
                                                               : $urandom_range(1, 6));
                keyword_roundtrip(lex, $urandom_range(0, 5));
            end else if (sel < 7) begin
                rand_lexeme(lex, $urandom_range(17, 20));
                send_lexeme(lex);
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    it = rand_item();
                    send(it);
                end
            end
        end
    endtask

    initial begin
        logic [7:0] idents[$];
        sb             = new();
        transfers      = 0;
        last_transfers = 0;
        idle_cycles    = 0;
        items_sent     = 0;
        no_gaps        = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 8'd0;
        i_kind         = KIND_QUERY;
        i_data_byte    = 8'd0;
        i_last         = 1'b0;
        i_target_index = 8'd0;
        i_byte_position = 4'd0;
        i_key_length   = 5'd0;
        i_token_code   = 8'd0;
        i_entry_valid  = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed();
        random_phase(150);
        idents = '{8'hff, 8'h00, 8'($urandom_range(1, 254)), 8'h80};
        foreach (idents[i]) begin
            write_ident(idents[i]);
            random_phase(200);
        end

        wait_idle();
        if (sb.fails == 0 && sb.lookups.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (sb.lookups.size() != 0)
                $error("%0d lookups never answered", sb.lookups.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/kphl_pkg.sv
rtl/kphl_ctrl.sv
rtl/kphl_mul64.sv
rtl/kphl_dp.sv
rtl/keyword_perfect_hash_lookup_unit.sv
tb/tb_keyword_perfect_hash_lookup_unit.sv
